>>> rtl/ppdh_pkg.sv
// Shared types and constants of the periodic pair-distance histogram.
// No dependencies; used by every other file of the block but ppdh_ram.
package ppdh_pkg;

   localparam int CNT_W   = 48;
   localparam int SLOT_W  = 13;
   localparam int BIN_W   = 4;
   localparam int BOX_W   = 25;
   localparam int SIDE_W  = 4;
   localparam int NBIN_W  = 5;
   localparam int CSR_IDX_W = 2;
   localparam int LBL_W   = 3;
   localparam int NS_W    = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_COUNT  = 2'd0,
      OP_EDGE   = 2'd1,
      OP_BIN_RD = 2'd2,
      OP_SUB_RD = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_LENGTH = 2'd0,
      CSR_SIDE       = 2'd1,
      CSR_BINS       = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_idx_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DIST  = 7'b0000100,
      ST_LOOK  = 7'b0001000,
      ST_ISSUE = 7'b0010000,
      ST_UPD   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      bump = (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

>>> rtl/ppdh_req_if.sv
// Request channel of the pair histogram: valid/ready plus one pair or command word.
// Depends on ppdh_pkg.
interface ppdh_req_if #(parameter int COORD_BITS = 24);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  op;
   logic [COORD_BITS-1:0]       first_x;
   logic [COORD_BITS-1:0]       first_y;
   logic [COORD_BITS-1:0]       first_z;
   logic [COORD_BITS-1:0]       second_x;
   logic [COORD_BITS-1:0]       second_y;
   logic [COORD_BITS-1:0]       second_z;
   logic [ppdh_pkg::LBL_W-1:0]  label_a;
   logic [ppdh_pkg::LBL_W-1:0]  label_b;
   logic [ppdh_pkg::LBL_W-1:0]  label_c;
   logic [ppdh_pkg::SLOT_W-1:0] slot;
   logic [ppdh_pkg::CNT_W-1:0]  edge_value;

   modport source (output valid, op, first_x, first_y, first_z, second_x, second_y,
                   second_z, label_a, label_b, label_c, slot, edge_value,
                   input ready);
   modport sink (input valid, op, first_x, first_y, first_z, second_x, second_y,
                 second_z, label_a, label_b, label_c, slot, edge_value,
                 output ready);
endinterface

>>> rtl/ppdh_rsp_if.sv
// Response channel of the pair histogram: valid/ready plus one result word.
// Depends on ppdh_pkg.
interface ppdh_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic [ppdh_pkg::BIN_W-1:0] bin;
   logic [ppdh_pkg::CNT_W-1:0] count_value;

   modport source (output valid, hit, bin, count_value, input ready);
   modport sink (input valid, hit, bin, count_value, output ready);
endinterface

>>> rtl/ppdh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppdh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/ppdh_dist.sv
// Three-stage squared-distance pipeline with periodic minimum-image wrap.
// Depends on ppdh_pkg.
module ppdh_dist #(
   parameter int COORD_BITS = 24,
   localparam int GAP_W = (COORD_BITS > ppdh_pkg::BOX_W) ? COORD_BITS : ppdh_pkg::BOX_W,
   localparam int D2_W  = 2 * GAP_W + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ppdh_pkg::BOX_W-1:0] box_length,
   input  logic [COORD_BITS-1:0]      first_x,
   input  logic [COORD_BITS-1:0]      first_y,
   input  logic [COORD_BITS-1:0]      first_z,
   input  logic [COORD_BITS-1:0]      second_x,
   input  logic [COORD_BITS-1:0]      second_y,
   input  logic [COORD_BITS-1:0]      second_z,
   output logic                       done,
   output logic [D2_W-1:0]            d2
);
   logic [2:0] vld_ff, vld_in;
   logic [GAP_W-1:0] gx_ff, gy_ff, gz_ff;
   logic [2*GAP_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [D2_W-1:0] d2_ff;

   function automatic logic [GAP_W-1:0] gap(input logic [COORD_BITS-1:0] p,
                                            input logic [COORD_BITS-1:0] q,
                                            input logic [ppdh_pkg::BOX_W-1:0] len);
      logic [GAP_W:0] a;
      logic [GAP_W:0] l;
      a = (p > q) ? (GAP_W+1)'(p - q) : (GAP_W+1)'(q - p);
      l = (GAP_W+1)'(len);
      // wrap when the direct gap exceeds half the box
      if ((a << 1) > l) begin
         a = (a > l) ? a - l : l - a;
      end
      gap = a[GAP_W-1:0];
   endfunction

   assign vld_in = {vld_ff[1:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff <= gap(first_x, second_x, box_length);
      gy_ff <= gap(first_y, second_y, box_length);
      gz_ff <= gap(first_z, second_z, box_length);
      sx_ff <= gx_ff * gx_ff;
      sy_ff <= gy_ff * gy_ff;
      sz_ff <= gz_ff * gz_ff;
      d2_ff <= D2_W'(sx_ff) + D2_W'(sy_ff) + D2_W'(sz_ff);
   end

   assign done = vld_ff[2];
   assign d2   = d2_ff;
endmodule

>>> rtl/periodic_pair_distance_histogram.sv
// Periodic pair-distance histogram, top level.
// Request channel req_ch carries one word per item: op 0 counts a point pair,
// op 1 writes a squared bin edge, op 2 reads a bin counter, op 3 reads a
// subsample counter (slot = subsample * NBINS + bin). Every request gives
// exactly one response word on rsp_ch: hit, bin and the updated or read count.
// Configuration is written through csr_wr_en/csr_index/csr_wr_data; the user
// must do so only while idle, unchecked by the block. Throughput: one item at
// a time. A pair goes from acceptance through the 3-stage distance pipeline,
// edge compare, counter memory read and write-back to the response register;
// other ops skip the pipeline and edge compare. The next request is taken in
// the cycle after the response is loaded, even while that response still waits
// for the receiver. A stalled receiver holds the response register; the block
// then stops after computing the next result until the register frees up.
// Reset: edges and bin counters clear at once; the subsample counter memory
// is cleared by a pass over its MAX_SIDE^3 * NBINS entries (8192 by default)
// during which no request is accepted. Counters saturate at 2^48 - 1.
// Depends on ppdh_pkg, ppdh_req_if, ppdh_rsp_if, ppdh_ram and ppdh_dist.
module periodic_pair_distance_histogram #(
   parameter int NBINS      = 16,
   parameter int MAX_SIDE   = 8,
   parameter int COORD_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   ppdh_req_if.sink                       req_ch,
   ppdh_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [ppdh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ppdh_pkg::BOX_W-1:0]     csr_wr_data
);
   localparam int SUB_DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE * NBINS;
   localparam int SUB_AW = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
   localparam int BIN_AW = (NBINS > 1) ? $clog2(NBINS) : 1;
   localparam int NB_W   = $clog2(NBINS + 1);
   localparam int GAP_W  = (COORD_BITS > ppdh_pkg::BOX_W) ? COORD_BITS : ppdh_pkg::BOX_W;
   localparam int D2_W   = 2 * GAP_W + 2;
   localparam int CNT_W  = ppdh_pkg::CNT_W;

   ppdh_pkg::state_type state_ff, state_in;

   // configuration
   logic [ppdh_pkg::BOX_W-1:0]  box_ff;
   logic [ppdh_pkg::SIDE_W-1:0] side_ff;
   logic [ppdh_pkg::NBIN_W-1:0] nbins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff   <= ppdh_pkg::BOX_W'(25'h1000000);
         side_ff  <= ppdh_pkg::SIDE_W'(1);
         nbins_ff <= ppdh_pkg::NBIN_W'(16);
      end else if (csr_wr_en) begin
         case (ppdh_pkg::csr_idx_type'(csr_index))
            ppdh_pkg::CSR_BOX_LENGTH: box_ff   <= csr_wr_data;
            ppdh_pkg::CSR_SIDE:       side_ff  <= csr_wr_data[ppdh_pkg::SIDE_W-1:0];
            ppdh_pkg::CSR_BINS:       nbins_ff <= csr_wr_data[ppdh_pkg::NBIN_W-1:0];
            default: ;
         endcase
      end
   end

   // request hold register
   logic [1:0]                  op_ff;
   logic [COORD_BITS-1:0]       fx_ff, fy_ff, fz_ff, sx_ff, sy_ff, sz_ff;
   logic [ppdh_pkg::LBL_W-1:0]  la_ff, lb_ff, lc_ff;
   logic [ppdh_pkg::SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]            ev_ff;

   logic accept;
   assign req_ch.ready = (state_ff == ppdh_pkg::ST_IDLE);
   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_ch.op;
         fx_ff   <= req_ch.first_x;
         fy_ff   <= req_ch.first_y;
         fz_ff   <= req_ch.first_z;
         sx_ff   <= req_ch.second_x;
         sy_ff   <= req_ch.second_y;
         sz_ff   <= req_ch.second_z;
         la_ff   <= req_ch.label_a;
         lb_ff   <= req_ch.label_b;
         lc_ff   <= req_ch.label_c;
         slot_ff <= req_ch.slot;
         ev_ff   <= req_ch.edge_value;
      end
   end

   // distance pipeline
   logic            dist_start, dist_done;
   logic [D2_W-1:0] d2;

   assign dist_start = (state_ff == ppdh_pkg::ST_IDLE) && accept &&
                       (ppdh_pkg::op_type'(req_ch.op) == ppdh_pkg::OP_COUNT);

   ppdh_dist #(.COORD_BITS(COORD_BITS)) u_dist (
      .clock      (clock),
      .reset      (reset),
      .start      (dist_start),
      .box_length (box_ff),
      .first_x    (fx_ff),
      .first_y    (fy_ff),
      .first_z    (fz_ff),
      .second_x   (sx_ff),
      .second_y   (sy_ff),
      .second_z   (sz_ff),
      .done       (dist_done),
      .d2         (d2)
   );

   // edge table
   logic [CNT_W-1:0] edge_ff [NBINS+1];
   logic [31:0]      slot_wide;
   assign slot_wide = 32'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NBINS; i++) edge_ff[i] <= '0;
      end else if (state_ff == ppdh_pkg::ST_ISSUE &&
                   ppdh_pkg::op_type'(op_ff) == ppdh_pkg::OP_EDGE &&
                   slot_wide <= 32'(NBINS)) begin
         edge_ff[NB_W'(slot_wide)] <= ev_ff;
      end
   end

   // bin lookup: highest n below the bins in use with d2 above its edge
   logic [NB_W-1:0]   nb;
   logic              in_range, found;
   logic [BIN_AW-1:0] n_sel;

   always_comb begin
      nb = (32'(nbins_ff) > 32'(NBINS)) ? NB_W'(NBINS) : NB_W'(nbins_ff);
      in_range = (nb != '0) && (d2 <= D2_W'(edge_ff[nb]));
      found = 1'b0;
      n_sel = '0;
      for (int i = 0; i < NBINS; i++) begin
         if (32'(i) < 32'(nb) && d2 > D2_W'(edge_ff[i])) begin
            found = 1'b1;
            n_sel = BIN_AW'(i);
         end
      end
   end

   // subsample index
   logic [ppdh_pkg::NS_W-1:0] side, ns, side_cube;
   always_comb begin
      side = (32'(side_ff) > 32'(MAX_SIDE)) ? ppdh_pkg::NS_W'(MAX_SIDE)
                                            : ppdh_pkg::NS_W'(side_ff);
      ns = ppdh_pkg::NS_W'(lc_ff) +
           side * (ppdh_pkg::NS_W'(lb_ff) + side * ppdh_pkg::NS_W'(la_ff));
      side_cube = side * side * side;
   end

   logic              hit_ff, sub_ok_ff;
   logic [BIN_AW-1:0] n_ff;
   logic [SUB_AW-1:0] sub_idx_ff;
   logic [31:0]       sub_idx_wide;
   assign sub_idx_wide = 32'(ns) * 32'(NBINS) + 32'(n_sel);

   always_ff @(posedge clock) begin
      if (state_ff == ppdh_pkg::ST_LOOK) begin
         hit_ff     <= in_range && found;
         n_ff       <= n_sel;
         sub_ok_ff  <= ns < side_cube;
         sub_idx_ff <= sub_idx_wide[SUB_AW-1:0];
      end
   end

   // counter memories
   logic [SUB_AW:0]    clr_ff, clr_in;
   logic [NBINS-1:0]   bin_vld_ff;
   logic [BIN_AW-1:0]  bin_raddr;
   logic [CNT_W-1:0]   bin_rdata, bin_cur, bin_new;
   logic               bin_we;
   logic [SUB_AW-1:0]  sub_raddr, sub_waddr;
   logic [CNT_W-1:0]   sub_rdata, sub_wdata;
   logic               sub_we;
   logic               bin_rd_ok, sub_rd_ok, cur_vld_ff;
   logic [31:0]        sub_slot_lim;

   assign sub_slot_lim = 32'(SUB_DEPTH);
   assign bin_rd_ok = slot_wide < 32'(NBINS);
   assign sub_rd_ok = slot_wide < sub_slot_lim;

   assign bin_raddr = (ppdh_pkg::op_type'(op_ff) == ppdh_pkg::OP_COUNT) ? n_ff
                                                              : slot_wide[BIN_AW-1:0];
   assign sub_raddr = (ppdh_pkg::op_type'(op_ff) == ppdh_pkg::OP_COUNT) ? sub_idx_ff
                                                              : slot_wide[SUB_AW-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ppdh_pkg::ST_ISSUE) begin
         cur_vld_ff <= bin_vld_ff[bin_raddr];
      end
   end

   // a never-written bin counter reads as zero
   assign bin_cur = cur_vld_ff ? bin_rdata : '0;
   assign bin_new = ppdh_pkg::bump(bin_cur);

   logic upd_count;
   assign upd_count = (state_ff == ppdh_pkg::ST_UPD) &&
                      (ppdh_pkg::op_type'(op_ff) == ppdh_pkg::OP_COUNT) && hit_ff;
   assign bin_we = upd_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff <= '0;
      end else if (bin_we) begin
         bin_vld_ff[n_ff] <= 1'b1;
      end
   end

   always_comb begin
      if (state_ff == ppdh_pkg::ST_CLEAR) begin
         sub_we    = 1'b1;
         sub_waddr = clr_ff[SUB_AW-1:0];
         sub_wdata = '0;
      end else begin
         sub_we    = upd_count && sub_ok_ff;
         sub_waddr = sub_idx_ff;
         sub_wdata = ppdh_pkg::bump(sub_rdata);
      end
   end

   ppdh_ram #(.WIDTH(CNT_W), .DEPTH(NBINS)) u_bin_ram (
      .clock (clock),
      .we    (bin_we),
      .waddr (n_ff),
      .wdata (bin_new),
      .raddr (bin_raddr),
      .rdata (bin_rdata)
   );

   ppdh_ram #(.WIDTH(CNT_W), .DEPTH(SUB_DEPTH)) u_sub_ram (
      .clock (clock),
      .we    (sub_we),
      .waddr (sub_waddr),
      .wdata (sub_wdata),
      .raddr (sub_raddr),
      .rdata (sub_rdata)
   );

   // result staging and output register
   logic                       res_hit_ff;
   logic [ppdh_pkg::BIN_W-1:0] res_bin_ff;
   logic [CNT_W-1:0]           res_val_ff;
   logic                       out_vld_ff, out_vld_in;
   logic                       out_hit_ff;
   logic [ppdh_pkg::BIN_W-1:0] out_bin_ff;
   logic [CNT_W-1:0]           out_val_ff;
   logic                       out_free, out_load;

   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign out_load = (state_ff == ppdh_pkg::ST_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (state_ff == ppdh_pkg::ST_UPD) begin
         res_hit_ff <= 1'b0;
         res_bin_ff <= '0;
         res_val_ff <= '0;
         case (ppdh_pkg::op_type'(op_ff))
            ppdh_pkg::OP_COUNT: begin
               if (hit_ff) begin
                  res_hit_ff <= 1'b1;
                  res_bin_ff <= ppdh_pkg::BIN_W'(32'(n_ff));
                  res_val_ff <= bin_new;
               end
            end
            ppdh_pkg::OP_BIN_RD: begin
               if (bin_rd_ok) res_val_ff <= bin_cur;
            end
            ppdh_pkg::OP_SUB_RD: begin
               if (sub_rd_ok) res_val_ff <= sub_rdata;
            end
            default: ;
         endcase
      end
   end

   assign out_vld_in = out_load || (out_vld_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_hit_ff <= res_hit_ff;
         out_bin_ff <= res_bin_ff;
         out_val_ff <= res_val_ff;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.hit         = out_hit_ff;
   assign rsp_ch.bin         = out_bin_ff;
   assign rsp_ch.count_value = out_val_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ppdh_pkg::ST_CLEAR: begin
            clr_in = clr_ff + (SUB_AW+1)'(1);
            if (clr_ff == (SUB_AW+1)'(SUB_DEPTH - 1)) state_in = ppdh_pkg::ST_IDLE;
         end
         ppdh_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (ppdh_pkg::op_type'(req_ch.op) == ppdh_pkg::OP_COUNT)
                          ? ppdh_pkg::ST_DIST : ppdh_pkg::ST_ISSUE;
            end
         end
         ppdh_pkg::ST_DIST:  if (dist_done) state_in = ppdh_pkg::ST_LOOK;
         ppdh_pkg::ST_LOOK:  state_in = ppdh_pkg::ST_ISSUE;
         ppdh_pkg::ST_ISSUE: state_in = ppdh_pkg::ST_UPD;
         ppdh_pkg::ST_UPD:   state_in = ppdh_pkg::ST_DONE;
         ppdh_pkg::ST_DONE:  if (out_free) state_in = ppdh_pkg::ST_IDLE;
         default:            state_in = ppdh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppdh_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

endmodule
